/* rtl/ssoc_pkg.sv */
// Shared constants and payload types for the sorted store occurrence counter.
// No dependencies; imported by ssoc_seq and the top level of the block.
package ssoc_pkg;

    localparam int STORE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int VALUE_W     = 32;
    localparam int MATCH_W     = 11;

    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_COUNT   = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic                      req_type;
        logic signed [VALUE_W-1:0] item_value;
    } ssoc_in_t;

    typedef struct packed {
        logic [MATCH_W-1:0] match_count;
        logic               status;
    } ssoc_out_t;

endpackage

/* rtl/ssoc_ram.sv */
// Generic synchronous RAM: one write port, two read ports, registered read data.
// No dependencies.
module ssoc_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr_a,
    output logic [WIDTH-1:0]  rdata_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [WIDTH-1:0]  rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

/* rtl/ssoc_seq.sv */
// Request sequencer: two parallel binary searches over the sorted RAM and the
// shift-and-insert pass for loads. Depends on ssoc_pkg and ssoc_ram.
module ssoc_seq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  ssoc_pkg::ssoc_in_t  in_data,
    output logic              res_valid,
    input  logic              res_ready,
    output ssoc_pkg::ssoc_out_t res_data
);
    import ssoc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_CMP,
        ST_SHIFT,
        ST_FLUSH,
        ST_PUT,
        ST_DONE
    } state_t;

    state_t            state_reg;
    ssoc_in_t          req_reg;
    ssoc_out_t         res_reg;
    logic [CNT_W-1:0]  cnt_reg;
    // upper-bound (strict) and lower-bound search windows
    logic [CNT_W-1:0]  lo_u_reg, hi_u_reg, mid_u_reg;
    logic [CNT_W-1:0]  lo_l_reg, hi_l_reg, mid_l_reg;
    logic [CNT_W-1:0]  shift_idx_reg;
    logic              wr_pend_reg;
    logic [ADDR_W-1:0] wr_addr_reg;

    logic [CNT_W-1:0]   mid_u, mid_l, shift_dec;
    logic               done_u, done_l;
    logic               we;
    logic [ADDR_W-1:0]  waddr, raddr_a, raddr_b;
    logic [VALUE_W-1:0] wdata, rdata_a, rdata_b;

    assign mid_u     = lo_u_reg + ((hi_u_reg - lo_u_reg) >> 1);
    assign mid_l     = lo_l_reg + ((hi_l_reg - lo_l_reg) >> 1);
    assign done_u    = (hi_u_reg == lo_u_reg);
    assign done_l    = (hi_l_reg == lo_l_reg);
    assign shift_dec = shift_idx_reg - CNT_W'(1);

    always_comb begin
        raddr_a = (state_reg == ST_SHIFT) ? shift_dec[ADDR_W-1:0] : mid_u[ADDR_W-1:0];
        raddr_b = mid_l[ADDR_W-1:0];
        we      = 1'b0;
        waddr   = wr_addr_reg;
        wdata   = rdata_a;
        unique case (state_reg)
            ST_SHIFT, ST_FLUSH: begin
                we = wr_pend_reg;
            end
            ST_PUT: begin
                we    = 1'b1;
                waddr = hi_u_reg[ADDR_W-1:0];
                wdata = req_reg.item_value;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    ssoc_ram #(
        .DEPTH (STORE_DEPTH),
        .WIDTH (VALUE_W),
        .ADDR_W(ADDR_W)
    ) u_ram (
        .aclk   (aclk),
        .we     (we),
        .waddr  (waddr),
        .wdata  (wdata),
        .raddr_a(raddr_a),
        .rdata_a(rdata_a),
        .raddr_b(raddr_b),
        .rdata_b(rdata_b)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res_data  = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            wr_pend_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_valid) begin
                        req_reg  <= in_data;
                        lo_u_reg <= '0;
                        hi_u_reg <= cnt_reg;
                        lo_l_reg <= '0;
                        hi_l_reg <= cnt_reg;
                        if (in_data.req_type == REQ_LOAD &&
                            cnt_reg == CNT_W'(STORE_DEPTH)) begin
                            res_reg.match_count <= '0;
                            res_reg.status      <= STATUS_FULL;
                            state_reg           <= ST_DONE;
                        end else begin
                            state_reg <= ST_ISSUE;
                        end
                    end
                end
                ST_ISSUE: begin
                    if (done_u && done_l) begin
                        if (req_reg.req_type == REQ_COUNT) begin
                            res_reg.match_count <= MATCH_W'(hi_u_reg - lo_l_reg);
                            res_reg.status      <= STATUS_OK;
                            state_reg           <= ST_DONE;
                        end else if (cnt_reg > hi_u_reg) begin
                            shift_idx_reg <= cnt_reg;
                            wr_pend_reg   <= 1'b0;
                            state_reg     <= ST_SHIFT;
                        end else begin
                            state_reg <= ST_PUT;
                        end
                    end else begin
                        mid_u_reg <= mid_u;
                        mid_l_reg <= mid_l;
                        state_reg <= ST_CMP;
                    end
                end
                ST_CMP: begin
                    if (!done_u) begin
                        if ($signed(rdata_a) > req_reg.item_value) begin
                            hi_u_reg <= mid_u_reg;
                        end else begin
                            lo_u_reg <= mid_u_reg + CNT_W'(1);
                        end
                    end
                    if (!done_l) begin
                        if ($signed(rdata_b) >= req_reg.item_value) begin
                            hi_l_reg <= mid_l_reg;
                        end else begin
                            lo_l_reg <= mid_l_reg + CNT_W'(1);
                        end
                    end
                    state_reg <= ST_ISSUE;
                end
                ST_SHIFT: begin
                    // read entry i-1 now, it lands in entry i next cycle
                    wr_pend_reg   <= 1'b1;
                    wr_addr_reg   <= shift_idx_reg[ADDR_W-1:0];
                    shift_idx_reg <= shift_dec;
                    if (shift_dec == hi_u_reg) begin
                        state_reg <= ST_FLUSH;
                    end
                end
                ST_FLUSH: begin
                    wr_pend_reg <= 1'b0;
                    state_reg   <= ST_PUT;
                end
                ST_PUT: begin
                    cnt_reg             <= cnt_reg + CNT_W'(1);
                    res_reg.match_count <= '0;
                    res_reg.status      <= STATUS_OK;
                    state_reg           <= ST_DONE;
                end
                ST_DONE: begin
                    if (res_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/sorted_store_occurrence_count_top.sv */
// Top level of the sorted store occurrence counter: sequencer plus result register.
// Depends on ssoc_pkg and ssoc_seq.
//
// Keeps up to 1024 signed 32-bit values in ascending order in a one-write,
// two-read synchronous RAM. A count request runs the lower- and upper-bound
// binary searches side by side on the two read ports; each search step is one
// RAM read plus one compare. A load runs the same search, then moves every
// larger entry up one place through the single write port, one entry per
// cycle, and writes the new value. A load into a full store answers status 1.
// The result register lets the next request be taken while a result waits on
// m_ready.
module sorted_store_occurrence_count_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ssoc_pkg::ssoc_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ssoc_pkg::ssoc_out_t m_data
);
    import ssoc_pkg::*;

    logic      res_valid, res_ready;
    ssoc_out_t res_data;
    logic      m_valid_reg;
    ssoc_out_t m_data_reg;

    ssoc_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_data  (s_data),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res_data (res_data)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
            if (res_valid) begin
                m_data_reg <= res_data;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* tb/sorted_store_occurrence_count_top_test.sv */
// Self-checking testbench for sorted_store_occurrence_count_top: loads, counts and full-store drops.
// Depends on ssoc_pkg and the block's RTL; the expected results come from a queue-based
// sorted store kept alongside the block.
module sorted_store_occurrence_count_top_test;
    import ssoc_pkg::*;

    localparam int CYCLE_LIMIT = 6_000_000;
    localparam logic signed [VALUE_W-1:0] INT_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

    typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    ssoc_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    ssoc_out_t m_data;

    // sorted copy of what the block should hold, and the results still owed
    logic signed [VALUE_W-1:0] shadow_store[$];
    ssoc_out_t                 pending_results[$];

    int       fail_count  = 0;
    int       cycle_count = 0;
    int       burst_left  = 0;
    rx_mode_t rx_mode     = RX_ALWAYS;
    int       rx_left     = 0;
    ssoc_out_t want;

    sorted_store_occurrence_count_top uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // First index whose value is > v (strict) or >= v.
    function automatic int bound_index(logic signed [VALUE_W-1:0] v, bit strict);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = shadow_store.size();
        while (hi > lo) begin
            mid = lo + (hi - lo) / 2;
            if (strict ? (shadow_store[mid] > v) : (shadow_store[mid] >= v))
                hi = mid;
            else
                lo = mid + 1;
        end
        return hi;
    endfunction

    function automatic void store_and_count(ssoc_in_t req);
        ssoc_out_t                 res;
        logic signed [VALUE_W-1:0] v;
        int                        hits;
        v = req.item_value;
        res.match_count = '0;
        res.status      = STATUS_OK;
        if (req.req_type == REQ_LOAD) begin
            if (shadow_store.size() >= STORE_DEPTH)
                res.status = STATUS_FULL;
            else
                shadow_store.insert(bound_index(v, 1'b1), v);
        end else begin
            hits = bound_index(v, 1'b1) - bound_index(v, 1'b0);
            res.match_count = hits[MATCH_W-1:0];
        end
        pending_results.push_back(res);
    endfunction

    // Mostly a small pool so duplicates pile up; queries often hit stored values or neighbors.
    function automatic logic signed [VALUE_W-1:0] pick_value(bit for_query);
        int roll;
        int idx;
        int offset;
        roll = $urandom_range(0, 99);
        if (for_query && shadow_store.size() > 0 && roll < 35) begin
            idx    = $urandom_range(0, shadow_store.size() - 1);
            offset = int'($urandom_range(0, 2)) - 1;
            return shadow_store[idx] + offset;
        end
        if (roll < 60)
            return int'($urandom_range(0, 16)) - 8;
        if (roll < 75) begin
            case ($urandom_range(0, 5))
                0: return INT_MIN;
                1: return INT_MIN + 1;
                2: return -1;
                3: return 0;
                4: return INT_MAX - 1;
                default: return INT_MAX;
            endcase
        end
        return $urandom();
    endfunction

    task automatic send_request(input logic kind, input logic signed [VALUE_W-1:0] value);
        ssoc_in_t req;
        int       gap;
        req.req_type   = kind;
        req.item_value = value;
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        store_and_count(req);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // receiver backpressure: modes held for random stretches
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(16, 400);
            end else begin
                rx_left--;
            end
            case (rx_mode)
                RX_ALWAYS: m_ready <= 1'b1;
                RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_ready <= ($urandom_range(0, 7) == 0);
                default:   m_ready <= (cycle_count % 32 < 24);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing outstanding: match_count %0d status %0d",
                       m_data.match_count, m_data.status);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_data.match_count !== want.match_count) begin
                    $error("match_count: expected %0d, got %0d",
                           want.match_count, m_data.match_count);
                    fail_count++;
                end
                if (m_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_data.status);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_empty_store();
        send_request(REQ_COUNT, 0);
        send_request(REQ_COUNT, -1);
        send_request(REQ_COUNT, INT_MIN);
        send_request(REQ_COUNT, INT_MAX);
    endtask

    // extremes, duplicates, and out-of-order loads that force entries to shift up
    task automatic test_directed_loads();
        send_request(REQ_LOAD, INT_MAX);
        send_request(REQ_LOAD, INT_MIN);
        send_request(REQ_LOAD, 0);
        send_request(REQ_LOAD, 5);
        send_request(REQ_LOAD, 5);
        send_request(REQ_LOAD, -1);
        send_request(REQ_LOAD, 5);
        send_request(REQ_LOAD, 3);
        send_request(REQ_LOAD, INT_MIN);
        send_request(REQ_COUNT, 5);
        send_request(REQ_COUNT, INT_MIN);
        send_request(REQ_COUNT, INT_MAX);
        send_request(REQ_COUNT, 4);
        send_request(REQ_COUNT, 0);
        send_request(REQ_COUNT, -1);
        send_request(REQ_COUNT, INT_MAX - 1);
        send_request(REQ_COUNT, INT_MIN + 1);
    endtask

    // filling the store later adds about a thousand loads, so the mix stays short
    task automatic test_random_mix();
        logic kind;
        for (int i = 0; i < 200; i++) begin
            kind = ($urandom_range(0, 99) < 45) ? REQ_LOAD : REQ_COUNT;
            send_request(kind, pick_value(kind == REQ_COUNT));
        end
    endtask

    // top-end loads land after equal values, so filling moves nothing
    task automatic test_full_store();
        while (shadow_store.size() < STORE_DEPTH)
            send_request(REQ_LOAD, INT_MAX);
        send_request(REQ_LOAD, INT_MIN);
        send_request(REQ_LOAD, 0);
        send_request(REQ_LOAD, INT_MAX);
        for (int i = 0; i < 8; i++)
            send_request(REQ_LOAD, $urandom());
        send_request(REQ_COUNT, INT_MAX);
        send_request(REQ_COUNT, INT_MIN);
        send_request(REQ_COUNT, 0);
        for (int i = 0; i < 30; i++) begin
            if ($urandom_range(0, 3) == 0)
                send_request(REQ_LOAD, pick_value(1'b0));
            else
                send_request(REQ_COUNT, pick_value(1'b1));
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_store();
        test_directed_loads();
        test_random_mix();
        test_full_store();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
